/* rtl/ngt_pkg.sv */
// Shared types, constants and the log2 lookup table of the gray-level transform.
package ngt_pkg;

   localparam int PIXEL_BITS = 8;
   localparam int FRAC_BITS  = 16;
   localparam int LOG_BITS   = 20;
   localparam int LOG_DEPTH  = 256;
   localparam int EXP_TERMS  = 20;
   localparam int EXP_STAGES = 3 * EXP_TERMS;

   localparam logic [29:0] LN2_Q30 = 30'd744261118;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

   localparam logic [2:0] CSR_MODE      = 3'd0;
   localparam logic [2:0] CSR_OFFSET_A  = 3'd1;
   localparam logic [2:0] CSR_LOG_SCALE = 3'd2;
   localparam logic [2:0] CSR_EXP_RATE  = 3'd3;
   localparam logic [2:0] CSR_POW_GAIN  = 3'd4;
   localparam logic [2:0] CSR_POW_GAMMA = 3'd5;

   typedef enum logic [1:0] {
      MODE_ZERO = 2'd0,
      MODE_LOG  = 2'd1,
      MODE_EXP  = 2'd2,
      MODE_POW  = 2'd3
   } mode_type;

   typedef struct packed {
      logic       done;
      logic [7:0] pix;
      logic       clip;
      logic       is_pow;
      logic [4:0] n;
   } side_type;

   typedef logic [LOG_DEPTH-1:0][LOG_BITS-1:0] log_tab_type;

   function automatic logic [LOG_BITS-1:0] log2_fx(input int unsigned v);
      int unsigned       k;
      longint unsigned   m;
      longint unsigned   frac;
      k    = 0;
      frac = 0;
      for (int i = 1; i <= 10; i++) begin
         if ((v >> i) != 0) k = i;
      end
      m = longint'(v) << (FRAC_BITS - k);
      for (int i = 0; i < FRAC_BITS; i++) begin
         m    = (m * m) >> FRAC_BITS;
         frac = frac << 1;
         if (m >= (64'd2 << FRAC_BITS)) begin
            m    = m >> 1;
            frac = frac | 64'd1;
         end
      end
      return LOG_BITS'((longint'(k) << FRAC_BITS) + frac);
   endfunction

   function automatic log_tab_type build_log_table();
      log_tab_type tab;
      for (int i = 0; i < LOG_DEPTH; i++) begin
         tab[i] = log2_fx(i + 1);
      end
      return tab;
   endfunction

   localparam log_tab_type LOG_TABLE = build_log_table();

endpackage

/* rtl/ngt_exp2.sv */
// Pipelined 2^f unit: Taylor series of e^(f*ln2), three register stages per term.
module ngt_exp2 (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [15:0]       in_frac,
   input  ngt_pkg::side_type in_side,
   output logic              out_valid,
   output logic [31:0]       out_e,
   output ngt_pkg::side_type out_side
);
   import ngt_pkg::*;

   typedef struct packed {
      logic [30:0] t;
      logic [30:0] a;
      logic [30:0] q0;
      logic [31:0] sum;
      logic [29:0] y;
      side_type    side;
   } unit_type;

   unit_type st_ff  [0:EXP_STAGES];
   logic     vld_ff [0:EXP_STAGES];
   unit_type st0_in;
   logic [59:0] yprod;

   always_comb begin
      yprod         = 60'({in_frac, 14'b0}) * 60'(LN2_Q30);
      st0_in        = '0;
      st0_in.y      = yprod[59:30];
      st0_in.t      = ONE_Q30;
      st0_in.sum    = 32'(ONE_Q30);
      st0_in.side   = in_side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
      if (adv) begin
         st_ff[0] <= st0_in;
      end
   end

   for (genvar j = 1; j <= EXP_STAGES; j++) begin : g_stage
      localparam int PHASE = (j - 1) % 3;
      localparam int K = (j + 2) / 3;
      localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);
      unit_type    nxt;
      logic [60:0] tprod;
      logic [63:0] rprod;
      logic [35:0] qk;
      logic [35:0] rem;
      logic [30:0] term;

      always_comb begin
         nxt   = st_ff[j-1];
         tprod = '0;
         rprod = '0;
         qk    = '0;
         rem   = '0;
         term  = '0;
         case (PHASE)
            0: begin
               tprod = 61'(st_ff[j-1].t) * 61'(st_ff[j-1].y);
               nxt.a = tprod[60:30];
            end
            1: begin
               rprod  = 64'(st_ff[j-1].a) * 64'(RECIP);
               nxt.q0 = rprod[62:32];
            end
            default: begin
               qk      = 36'(st_ff[j-1].q0) * 36'(K);
               rem     = 36'(st_ff[j-1].a) - qk;
               term    = (rem >= 36'(K)) ? st_ff[j-1].q0 + 31'd1 : st_ff[j-1].q0;
               nxt.t   = term;
               nxt.sum = st_ff[j-1].sum + 32'(term);
            end
         endcase
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (adv) begin
            vld_ff[j] <= vld_ff[j-1];
         end
         if (adv) begin
            st_ff[j] <= nxt;
         end
      end
   end

   assign out_valid = vld_ff[EXP_STAGES];
   assign out_e     = st_ff[EXP_STAGES].sum;
   assign out_side  = st_ff[EXP_STAGES].side;

endmodule

/* rtl/nonlinear_gray_transform.sv */
// Top level of the log, exp and power-law gray-level transform.
//
// One 8-bit pixel enters on the req channel per beat and one result beat
// (pixel_out and clipped) leaves on the rsp channel for each, in order.
// Both channels move a beat at a clock edge where valid is high and stall
// is low. The csr port writes one register per cycle at csr_wr_en; write it
// only while no pixel is in flight.
// A new pixel is taken every cycle while req_stall is low; the 60 stages of
// the exp2 Taylor series (three per term) set the depth of the pipeline.
// When the receiver stalls, the result waits in the output register and the
// next one in a skid register; req_stall rises only once the skid register
// is full, and then the whole pipeline holds in place.
// Synchronous reset empties the pipeline and returns the registers to mode
// zero, zero offset, scale, rate and gain, and gamma of 1.0.
module nonlinear_gray_transform (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pixel_out,
   output logic        rsp_clipped,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [24:0] csr_wdata
);
   import ngt_pkg::*;

   mode_type           mode_ff;
   logic signed [16:0] offset_a_ff;
   logic signed [24:0] log_scale_ff;
   logic signed [24:0] exp_rate_ff;
   logic [23:0]        pow_gain_ff;
   logic [19:0]        pow_gamma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_ZERO;
         offset_a_ff  <= '0;
         log_scale_ff <= '0;
         exp_rate_ff  <= '0;
         pow_gain_ff  <= '0;
         pow_gamma_ff <= 20'd65536;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE:      mode_ff      <= mode_type'(csr_wdata[1:0]);
            CSR_OFFSET_A:  offset_a_ff  <= csr_wdata[16:0];
            CSR_LOG_SCALE: log_scale_ff <= csr_wdata[24:0];
            CSR_EXP_RATE:  exp_rate_ff  <= csr_wdata[24:0];
            CSR_POW_GAIN:  pow_gain_ff  <= csr_wdata[23:0];
            CSR_POW_GAMMA: pow_gamma_ff <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic skid_valid_ff;
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Stage 1: input register.
   logic       v1_ff;
   logic [7:0] x1_ff;

   // Stage 2: log table and exp difference.
   logic               v2_ff;
   logic [7:0]         x2_ff;
   logic [19:0]        l2_ff;
   logic signed [18:0] d2_ff;
   logic [7:0]         idx2_in;
   logic [18:0]        d2_in;

   // Stage 3: products.
   logic               v3_ff;
   logic               zero3_ff;
   logic signed [45:0] lsp3_ff;
   logic signed [43:0] p3_ff;
   logic [39:0]        e3_ff;
   logic signed [45:0] lsp3_in;
   logic signed [43:0] p3_in;

   // Stage 4: log sum and decoded exponents.
   logic        v4_ff;
   logic [46:0] s4_ff;
   logic        exp_pos4_ff;
   logic        exp_ovf4_ff;
   logic [3:0]  exp_n4_ff;
   logic [15:0] exp_fr4_ff;
   logic        pow_zero4_ff;
   logic        pow_ovf4_ff;
   logic [4:0]  pow_n4_ff;
   logic [15:0] pow_fr4_ff;

   assign idx2_in = (mode_ff == MODE_POW) ? x1_ff - 8'd1 : x1_ff;
   assign d2_in   = {3'b0, x1_ff, 8'b0} - {{2{offset_a_ff[16]}}, offset_a_ff};
   assign lsp3_in = 46'(log_scale_ff) * 46'($signed({1'b0, l2_ff}));
   assign p3_in   = 44'(exp_rate_ff) * 44'(d2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (adv) begin
         x1_ff        <= req_pixel_in;
         x2_ff        <= x1_ff;
         l2_ff        <= LOG_TABLE[idx2_in];
         d2_ff        <= d2_in;
         zero3_ff     <= (x2_ff == 8'd0) || (pow_gain_ff == 24'd0);
         lsp3_ff      <= lsp3_in;
         p3_ff        <= p3_in;
         e3_ff        <= 40'(l2_ff) * 40'(pow_gamma_ff);
         s4_ff        <= {{6{offset_a_ff[16]}}, offset_a_ff, 24'b0}
                         + {lsp3_ff[45], lsp3_ff};
         exp_pos4_ff  <= !p3_ff[43] && (p3_ff != '0);
         exp_ovf4_ff  <= p3_ff[42:28] > 15'd8;
         exp_n4_ff    <= p3_ff[31:28];
         exp_fr4_ff   <= p3_ff[27:12];
         pow_zero4_ff <= zero3_ff;
         pow_ovf4_ff  <= e3_ff[39:32] >= 8'd23;
         pow_n4_ff    <= e3_ff[36:32];
         pow_fr4_ff   <= e3_ff[31:16];
      end
   end

   side_type    side4;
   logic [15:0] frac4;

   always_comb begin
      side4       = '0;
      side4.done  = 1'b1;
      frac4       = '0;
      case (mode_ff)
         MODE_LOG: begin
            if (s4_ff[46]) begin
               side4.clip = !((&s4_ff[46:32]) && (s4_ff[31:0] != '0));
            end else if (s4_ff[46:32] > 15'd255) begin
               side4.pix  = 8'hff;
               side4.clip = 1'b1;
            end else begin
               side4.pix = s4_ff[39:32];
            end
         end
         MODE_EXP: begin
            if (exp_pos4_ff && exp_ovf4_ff) begin
               side4.pix  = 8'hff;
               side4.clip = 1'b1;
            end else if (exp_pos4_ff) begin
               side4.done = 1'b0;
               side4.n    = {1'b0, exp_n4_ff};
               frac4      = exp_fr4_ff;
            end
         end
         MODE_POW: begin
            if (!pow_zero4_ff && pow_ovf4_ff) begin
               side4.pix  = 8'hff;
               side4.clip = 1'b1;
            end else if (!pow_zero4_ff) begin
               side4.done   = 1'b0;
               side4.is_pow = 1'b1;
               side4.n      = pow_n4_ff;
               frac4        = pow_fr4_ff;
            end
         end
         default: ;
      endcase
   end

   logic        ve_out;
   logic [31:0] e_out;
   side_type    side_out;

   ngt_exp2 u_exp2 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .in_frac   (frac4),
      .in_side   (side4),
      .out_valid (ve_out),
      .out_e     (e_out),
      .out_side  (side_out)
   );

   // Stage Q1: gain product. Stage Q2: final scaling and clipping.
   logic        vq1_ff;
   side_type    side_q1_ff;
   logic [31:0] e_q1_ff;
   logic [54:0] m_q1_ff;
   logic        vq2_ff;
   logic [7:0]  pix_q2_ff;
   logic        clip_q2_ff;
   logic [7:0]  pix_q2_in;
   logic        clip_q2_in;
   logic [39:0] e_shift;
   logic [9:0]  e_val;
   logic [55:0] m_shift;
   logic [5:0]  m_amt;

   always_comb begin
      e_shift    = 40'(e_q1_ff) << side_q1_ff.n[3:0];
      e_val      = e_shift[39:30] - 10'd1;
      m_amt      = 6'd44 - 6'(side_q1_ff.n);
      m_shift    = 56'(m_q1_ff) >> m_amt;
      pix_q2_in  = side_q1_ff.pix;
      clip_q2_in = side_q1_ff.clip;
      if (!side_q1_ff.done) begin
         if (side_q1_ff.is_pow) begin
            clip_q2_in = m_shift[55:8] != '0;
            pix_q2_in  = clip_q2_in ? 8'hff : m_shift[7:0];
         end else begin
            clip_q2_in = e_val[9:8] != 2'b00;
            pix_q2_in  = clip_q2_in ? 8'hff : e_val[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vq1_ff <= 1'b0;
         vq2_ff <= 1'b0;
      end else if (adv) begin
         vq1_ff <= ve_out;
         vq2_ff <= vq1_ff;
      end
      if (adv) begin
         side_q1_ff <= side_out;
         e_q1_ff    <= e_out;
         m_q1_ff    <= 55'(pow_gain_ff) * 55'(e_out[30:0]);
         pix_q2_ff  <= pix_q2_in;
         clip_q2_ff <= clip_q2_in;
      end
   end

   // Output register with a skid register behind it.
   logic       out_valid_ff;
   logic [7:0] out_pix_ff;
   logic       out_clip_ff;
   logic [7:0] skid_pix_ff;
   logic       skid_clip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         out_valid_ff  <= skid_valid_ff || vq2_ff;
         skid_valid_ff <= 1'b0;
      end else if (vq2_ff && adv) begin
         skid_valid_ff <= 1'b1;
      end
      if (!out_valid_ff || !rsp_stall) begin
         out_pix_ff  <= skid_valid_ff ? skid_pix_ff : pix_q2_ff;
         out_clip_ff <= skid_valid_ff ? skid_clip_ff : clip_q2_ff;
      end else if (vq2_ff && adv) begin
         skid_pix_ff  <= pix_q2_ff;
         skid_clip_ff <= clip_q2_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pixel_out = out_pix_ff;
   assign rsp_clipped   = out_clip_ff;

endmodule

/* rtl/ngt_checker.sv */
// Port-level assertions for the gray-level transform and their binding.
module ngt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_pixel_in,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_pixel_out,
   input logic        rsp_clipped,
   input logic        csr_wr_en,
   input logic [2:0]  csr_index,
   input logic [24:0] csr_wdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result beat dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_pixel_out) && $stable(rsp_clipped))
      else $error("stalled result beat changed");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_pixel_out == 8'd0 || rsp_pixel_out == 8'hff)
      else $error("clipped beat carries an inner gray level");

endmodule

bind nonlinear_gray_transform ngt_checker u_ngt_checker (.*);
